@@ design/plane_wave_phase_rotator_top_assert.svh @@
// Assertion macros for the phase rotator; pwpr_mid_queue is the module using them.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef PLANE_WAVE_PHASE_ROTATOR_TOP_ASSERT_SVH
`define PLANE_WAVE_PHASE_ROTATOR_TOP_ASSERT_SVH

// Condition must never hold while out of reset
`define PWPR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define PWPR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/pwpr_pkg.sv @@
package pwpr_pkg;

    localparam int CORDIC_STEPS = 18;
    localparam int TABLE_LEN    = 24;
    // effective micro-rotation count, clamped to 1 and to the arctangent table
    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN :
                           ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);

    localparam int DATA_W = 24;
    localparam int GUARD  = 8;
    localparam int XY_W   = 35;
    localparam int Z_W    = 34;
    localparam int PROD_W = 60;

    // round(2^40 / 2pi), split into low 32 and high 6 bits
    localparam logic [37:0] INV_TWO_PI = 38'd174992710548;
    localparam logic [31:0] INV_TWO_PI_LO = INV_TWO_PI[31:0];
    localparam logic [5:0]  INV_TWO_PI_HI = INV_TWO_PI[37:32];
    // 1/K, 24 fraction bits
    localparam logic signed [24:0] INV_GAIN = 25'sd10188014;

    localparam int MID_DEPTH = 8;
    localparam int MID_AW    = $clog2(MID_DEPTH);
    localparam int OUT_DEPTH = 32;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    // atan(2^-i) in turns, 32 fraction bits
    localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [1:0] {
        REG_WAVE_X = 2'd0,
        REG_WAVE_Y = 2'd1,
        REG_WAVE_Z = 2'd2,
        REG_SPINOR = 2'd3
    } t_reg_idx;

    typedef logic signed [DATA_W-1:0] t_amp;

    typedef struct packed {
        t_amp wave_x;
        t_amp wave_y;
        t_amp wave_z;
        logic spinor;
    } t_cfg;

    typedef struct packed {
        t_amp up_re;
        t_amp up_im;
        t_amp dn_re;
        t_amp dn_im;
    } t_quad;

    // request handed from front to back
    typedef struct packed {
        logic signed [31:0] angle;
        logic               flip;
        t_quad              amp;
    } t_mid;

    // round half up at 32 fraction bits and saturate to 24 bits
    function automatic t_amp finish(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] s;
        logic signed [PROD_W-1:0] r;
        t_amp                     res;
        s = prod + (PROD_W'(1) <<< (DATA_W + GUARD - 1));
        r = s >>> (DATA_W + GUARD);
        if (r > PROD_W'(8388607)) begin
            res = 24'sh7FFFFF;
        end else if (r < -PROD_W'(8388608)) begin
            res = 24'sh800000;
        end else begin
            res = r[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ design/plane_wave_phase_rotator_top.sv @@
// Plane-wave phase rotator: each request (grid point x/y/z plus spin-up and
// spin-down amplitudes) leaves multiplied by exp(i k.r), k from the wave_x/y/z
// registers; with spinor_mode clear the spin-down pair passes unchanged.
// Throughput is one request per clock in both directions while full and empty
// stay low. Empty falls once a request has passed 4 front stages, the mid
// queue write, the back issue register, CORDIC_STEPS rotation stages, then the
// gain multiply, rounding and the result queue write. An 8-entry queue
// decouples the phase front end from the CORDIC back end, a 32-entry result
// queue absorbs pop stalls; full rises when front pipe and mid queue hold 8.
// Write configuration only while no request is in flight.
module plane_wave_phase_rotator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_pos_z,
    input  logic signed [23:0] i_up_real,
    input  logic signed [23:0] i_up_imag,
    input  logic signed [23:0] i_down_real,
    input  logic signed [23:0] i_down_imag,
    output logic        empty,
    input  logic        pop,
    output logic signed [23:0] o_rot_up_real,
    output logic signed [23:0] o_rot_up_imag,
    output logic signed [23:0] o_rot_down_real,
    output logic signed [23:0] o_rot_down_imag
);

    pwpr_pkg::t_cfg             r_cfg;
    logic [pwpr_pkg::MID_AW:0]  r_mid_used;

    pwpr_pkg::t_quad            in_amp;
    pwpr_pkg::t_quad            res;
    pwpr_pkg::t_mid             front_item, mid_item;
    logic                       accept, front_valid, mid_empty, mid_pop, back_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (pwpr_pkg::t_reg_idx'(i_cfg_addr))
                pwpr_pkg::REG_WAVE_X: r_cfg.wave_x <= i_cfg_wdata;
                pwpr_pkg::REG_WAVE_Y: r_cfg.wave_y <= i_cfg_wdata;
                pwpr_pkg::REG_WAVE_Z: r_cfg.wave_z <= i_cfg_wdata;
                pwpr_pkg::REG_SPINOR: r_cfg.spinor <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // front credit: requests in the front pipe plus entries in the mid queue
    assign accept  = push && !full;
    assign mid_pop = !mid_empty && back_ready;
    assign full    = (r_mid_used == (pwpr_pkg::MID_AW+1)'(pwpr_pkg::MID_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_used <= '0;
        end else begin
            r_mid_used <= r_mid_used + (pwpr_pkg::MID_AW+1)'(accept)
                                     - (pwpr_pkg::MID_AW+1)'(mid_pop);
        end
    end

    assign in_amp.up_re = i_up_real;
    assign in_amp.up_im = i_up_imag;
    assign in_amp.dn_re = i_down_real;
    assign in_amp.dn_im = i_down_imag;

    pwpr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_cfg   (r_cfg),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .i_amp   (in_amp),
        .o_valid (front_valid),
        .o_item  (front_item)
    );

    pwpr_mid_queue u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_item),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_item)
    );

    pwpr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (mid_pop),
        .i_item   (mid_item),
        .i_spinor (r_cfg.spinor),
        .o_ready  (back_ready),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_res    (res)
    );

    assign o_rot_up_real   = res.up_re;
    assign o_rot_up_imag   = res.up_im;
    assign o_rot_down_real = res.dn_re;
    assign o_rot_down_imag = res.dn_im;

endmodule

@@ design/pwpr_front.sv @@
module pwpr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pwpr_pkg::t_cfg   i_cfg,
    input  pwpr_pkg::t_amp   i_pos_x,
    input  pwpr_pkg::t_amp   i_pos_y,
    input  pwpr_pkg::t_amp   i_pos_z,
    input  pwpr_pkg::t_quad  i_amp,
    output logic             o_valid,
    output pwpr_pkg::t_mid   o_item
);

    logic                   r_v1, r_v2, r_v3, r_v4;
    logic signed [47:0]     r_px, r_py, r_pz;
    logic signed [49:0]     r_kr;
    logic [31:0]            r_m0, r_m1, r_m2;
    pwpr_pkg::t_quad        r_a1, r_a2, r_a3;
    pwpr_pkg::t_mid         r_item;

    logic [63:0]            kr64;
    logic [63:0]            prod_ac0;
    logic [37:0]            prod_ac1;
    logic [63:0]            prod_bc0;
    logic [31:0]            p_word;
    logic signed [32:0]     p_ext;
    logic signed [32:0]     n_angle;
    logic                   n_flip;

    // turn-fraction product, only bits 63:32 of the wrapped 64-bit product
    always_comb begin
        kr64     = 64'(r_kr);
        prod_ac0 = 64'(kr64[31:0]) * 64'(pwpr_pkg::INV_TWO_PI_LO);
        prod_ac1 = 38'(kr64[31:0]) * 38'(pwpr_pkg::INV_TWO_PI_HI);
        prod_bc0 = 64'(kr64[63:32]) * 64'(pwpr_pkg::INV_TWO_PI_LO);
    end

    // fold into [-1/4, 1/4] turn
    always_comb begin
        p_word  = r_m0 + r_m1 + r_m2;
        p_ext   = 33'(signed'(p_word));
        n_flip  = 1'b0;
        n_angle = p_ext;
        if (p_ext > 33'sd1073741824) begin
            n_flip  = 1'b1;
            n_angle = p_ext - 33'sd2147483648;
        end else if (p_ext < -33'sd1073741824) begin
            n_flip  = 1'b1;
            n_angle = p_ext + 33'sd2147483648;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_px <= i_cfg.wave_x * i_pos_x;
        r_py <= i_cfg.wave_y * i_pos_y;
        r_pz <= i_cfg.wave_z * i_pos_z;
        r_a1 <= i_amp;

        r_kr <= 50'(r_px) + 50'(r_py) + 50'(r_pz);
        r_a2 <= r_a1;

        r_m0 <= prod_ac0[63:32];
        r_m1 <= prod_ac1[31:0];
        r_m2 <= prod_bc0[31:0];
        r_a3 <= r_a2;

        r_item.angle <= n_angle[31:0];
        r_item.flip  <= n_flip;
        r_item.amp   <= r_a3;
    end

    assign o_valid = r_v4;
    assign o_item  = r_item;

endmodule

@@ design/pwpr_mid_queue.sv @@
`include "plane_wave_phase_rotator_top_assert.svh"

module pwpr_mid_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pwpr_pkg::t_mid  i_data,
    input  logic            i_pop,
    output logic            o_empty,
    output pwpr_pkg::t_mid  o_data
);

    pwpr_pkg::t_mid                 r_mem [pwpr_pkg::MID_DEPTH];
    logic [pwpr_pkg::MID_AW-1:0]    r_wp, r_rp;
    logic [pwpr_pkg::MID_AW:0]      r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (pwpr_pkg::MID_AW+1)'(i_push) - (pwpr_pkg::MID_AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    `PWPR_ASSERT_NEVER(a_no_overflow, i_push && !i_pop && r_cnt == (pwpr_pkg::MID_AW+1)'(pwpr_pkg::MID_DEPTH), "mid queue overflow")
    `PWPR_ASSERT_IMPLY(a_no_underflow, i_pop, !o_empty, "mid queue underflow")
    `PWPR_ASSERT_NEVER(a_cnt_range, r_cnt > (pwpr_pkg::MID_AW+1)'(pwpr_pkg::MID_DEPTH), "mid queue count out of range")

endmodule

@@ design/pwpr_back.sv @@
module pwpr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_issue,
    input  pwpr_pkg::t_mid   i_item,
    input  logic             i_spinor,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_empty,
    output pwpr_pkg::t_quad  o_res
);

    typedef struct packed {
        logic signed [pwpr_pkg::XY_W-1:0] xu;
        logic signed [pwpr_pkg::XY_W-1:0] yu;
        logic signed [pwpr_pkg::XY_W-1:0] xd;
        logic signed [pwpr_pkg::XY_W-1:0] yd;
        logic signed [pwpr_pkg::Z_W-1:0]  z;
        pwpr_pkg::t_amp                   dn_re;
        pwpr_pkg::t_amp                   dn_im;
    } t_cs;

    localparam int S = pwpr_pkg::STEPS;

    t_cs                                r_st [S+1];
    logic                               r_sv [S+1];
    logic signed [pwpr_pkg::PROD_W-1:0] r_mu_re, r_mu_im, r_md_re, r_md_im;
    pwpr_pkg::t_amp                     r_pd_re, r_pd_im;
    logic                               r_mv, r_fv;
    pwpr_pkg::t_quad                    r_fin;
    pwpr_pkg::t_quad                    r_oq [pwpr_pkg::OUT_DEPTH];
    logic [pwpr_pkg::OUT_AW-1:0]        r_owp, r_orp;
    logic [pwpr_pkg::OUT_AW:0]          r_ocnt, r_used;

    t_cs                                n_st0;
    logic                               o_pop;

    // guard bits and half-turn fold on the way in
    always_comb begin
        n_st0.xu    = pwpr_pkg::XY_W'(i_item.amp.up_re) <<< pwpr_pkg::GUARD;
        n_st0.yu    = pwpr_pkg::XY_W'(i_item.amp.up_im) <<< pwpr_pkg::GUARD;
        n_st0.xd    = pwpr_pkg::XY_W'(i_item.amp.dn_re) <<< pwpr_pkg::GUARD;
        n_st0.yd    = pwpr_pkg::XY_W'(i_item.amp.dn_im) <<< pwpr_pkg::GUARD;
        n_st0.z     = pwpr_pkg::Z_W'(i_item.angle);
        n_st0.dn_re = i_item.amp.dn_re;
        n_st0.dn_im = i_item.amp.dn_im;
        if (i_item.flip) begin
            n_st0.xu = -n_st0.xu;
            n_st0.yu = -n_st0.yu;
            n_st0.xd = -n_st0.xd;
            n_st0.yd = -n_st0.yd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else begin
            r_sv[0] <= i_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st0;
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < S; i++) begin : g_step
        t_cs cur;
        t_cs nxt;
        always_comb begin
            cur = r_st[i];
            nxt = cur;
            if (!cur.z[pwpr_pkg::Z_W-1]) begin
                nxt.xu = cur.xu - (cur.yu >>> i);
                nxt.yu = cur.yu + (cur.xu >>> i);
                nxt.xd = cur.xd - (cur.yd >>> i);
                nxt.yd = cur.yd + (cur.xd >>> i);
                nxt.z  = cur.z - pwpr_pkg::Z_W'(pwpr_pkg::ATAN_TURNS[i]);
            end else begin
                nxt.xu = cur.xu + (cur.yu >>> i);
                nxt.yu = cur.yu - (cur.xu >>> i);
                nxt.xd = cur.xd + (cur.yd >>> i);
                nxt.yd = cur.yd - (cur.xd >>> i);
                nxt.z  = cur.z + pwpr_pkg::Z_W'(pwpr_pkg::ATAN_TURNS[i]);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[i+1] <= 1'b0;
            end else begin
                r_sv[i+1] <= r_sv[i];
            end
        end
        always_ff @(posedge i_clk) begin
            r_st[i+1] <= nxt;
        end
    end

    // gain correction and saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_fv <= 1'b0;
        end else begin
            r_mv <= r_sv[S];
            r_fv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mu_re <= r_st[S].xu * pwpr_pkg::INV_GAIN;
        r_mu_im <= r_st[S].yu * pwpr_pkg::INV_GAIN;
        r_md_re <= r_st[S].xd * pwpr_pkg::INV_GAIN;
        r_md_im <= r_st[S].yd * pwpr_pkg::INV_GAIN;
        r_pd_re <= r_st[S].dn_re;
        r_pd_im <= r_st[S].dn_im;

        r_fin.up_re <= pwpr_pkg::finish(r_mu_re);
        r_fin.up_im <= pwpr_pkg::finish(r_mu_im);
        r_fin.dn_re <= i_spinor ? pwpr_pkg::finish(r_md_re) : r_pd_re;
        r_fin.dn_im <= i_spinor ? pwpr_pkg::finish(r_md_im) : r_pd_im;
    end

    // result queue and credit count covering requests in flight
    assign o_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
            r_used <= '0;
        end else begin
            if (r_fv) begin
                r_owp <= r_owp + 1'b1;
            end
            if (o_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= r_ocnt + (pwpr_pkg::OUT_AW+1)'(r_fv) - (pwpr_pkg::OUT_AW+1)'(o_pop);
            r_used <= r_used + (pwpr_pkg::OUT_AW+1)'(i_issue) - (pwpr_pkg::OUT_AW+1)'(o_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fv) begin
            r_oq[r_owp] <= r_fin;
        end
    end

    assign o_ready = (r_used != (pwpr_pkg::OUT_AW+1)'(pwpr_pkg::OUT_DEPTH));
    assign o_empty = (r_ocnt == '0);
    assign o_res   = r_oq[r_orp];

endmodule
